// ----- hdl/cls_pkg.sv -----
// Shared types and constants for the converter lifecycle sequencer.
// No dependencies; cls_step, the top level and the testbench import it.

package cls_pkg;

    // Field and register widths.
    localparam int CFG_WIDTH          = 16;
    localparam int DELAY_BITS_DEFAULT = 16;
    localparam logic [CFG_WIDTH-1:0] DELAY_CFG_RESET = 16'd10;

    // Lifecycle states.
    typedef enum logic [2:0] {
        ST_INIT    = 3'd0,
        ST_IDLE    = 3'd1,
        ST_STARTUP = 3'd2,
        ST_RUN     = 3'd3,
        ST_FAULT   = 3'd4
    } cls_state_t;

    // Commands posted by the scheduler.
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } cls_cmd_t;

    // Reasons a start command is refused.
    typedef enum logic [2:0] {
        REJ_NONE      = 3'd0,
        REJ_BINDING   = 3'd1,
        REJ_CONFIG    = 3'd2,
        REJ_FAULT     = 3'd3,
        REJ_DIRECTION = 3'd4
    } cls_reject_t;

    // One scheduler tick as captured in the input register.
    typedef struct packed {
        cls_cmd_t    posted_command;
        logic        hard_fault_latched;
        logic        callbacks_bound;
        logic        binding_ready;
        logic        setpoint_ready;
        logic [1:0]  setpoint_direction;
    } cls_tick_t;

    // Sequencer context that survives from tick to tick.
    typedef struct packed {
        cls_state_t  state;
        cls_cmd_t    pending;
        logic        held_direction;
        logic        run_permit;
        logic        lock_flag;
    } cls_ctx_t;

    // Result published for one tick.
    typedef struct packed {
        cls_state_t  current_state;
        logic        latched_direction;
        logic        run_allowed;
        logic        bridge_enable_pulse;
        logic        bridge_stop_pulse;
        logic        pwm_force_off;
        logic        latch_clear_pulse;
        logic        direction_locked;
        cls_reject_t start_reject;
    } cls_result_t;

endpackage

// ----- hdl/cls_if.sv -----
// Valid/ready channel interfaces for the tick requests and the results.
// No dependencies; field widths are fixed by the block's item format.

interface cls_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] posted_command;
    logic       hard_fault_latched;
    logic       callbacks_bound;
    logic       binding_ready;
    logic       setpoint_ready;
    logic [1:0] setpoint_direction;

    modport source (
        output valid, posted_command, hard_fault_latched, callbacks_bound,
               binding_ready, setpoint_ready, setpoint_direction,
        input  ready
    );
    modport sink (
        input  valid, posted_command, hard_fault_latched, callbacks_bound,
               binding_ready, setpoint_ready, setpoint_direction,
        output ready
    );
endinterface

interface cls_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] current_state;
    logic       latched_direction;
    logic       run_allowed;
    logic       bridge_enable_pulse;
    logic       bridge_stop_pulse;
    logic       pwm_force_off;
    logic       latch_clear_pulse;
    logic       direction_locked;
    logic [2:0] start_reject;

    modport source (
        output valid, current_state, latched_direction, run_allowed,
               bridge_enable_pulse, bridge_stop_pulse, pwm_force_off,
               latch_clear_pulse, direction_locked, start_reject,
        input  ready
    );
    modport sink (
        input  valid, current_state, latched_direction, run_allowed,
               bridge_enable_pulse, bridge_stop_pulse, pwm_force_off,
               latch_clear_pulse, direction_locked, start_reject,
        output ready
    );
endinterface

// ----- hdl/cls_step.sv -----
// Next-state and result logic for one scheduler tick of the sequencer.
// Depends on cls_pkg for the state, command, context and result types.

module cls_step #(
    parameter int DELAY_BITS = cls_pkg::DELAY_BITS_DEFAULT
) (
    input  cls_pkg::cls_tick_t            tick,
    input  cls_pkg::cls_ctx_t             ctx,
    input  logic [DELAY_BITS-1:0]         settle,
    input  logic [cls_pkg::CFG_WIDTH-1:0] delay_cfg,
    output cls_pkg::cls_ctx_t             ctx_next,
    output logic [DELAY_BITS-1:0]         settle_next,
    output cls_pkg::cls_result_t          result
);
    import cls_pkg::*;

    cls_cmd_t              cmd;
    cls_state_t            nxt;
    cls_reject_t           reject;
    logic                  en_p;
    logic                  stop_p;
    logic                  pwm_p;
    logic                  clr_p;
    logic [DELAY_BITS-1:0] settle_dec;

    // Counter value after one settling tick, saturating at zero.
    assign settle_dec = (settle != '0) ? settle - DELAY_BITS'(1) : settle;

    // State behavior, then exit and entry actions of a transition.
    always_comb
    begin
        ctx_next    = ctx;
        settle_next = settle;
        reject      = REJ_NONE;
        en_p        = 1'b0;
        stop_p      = 1'b0;
        pwm_p       = 1'b0;
        clr_p       = 1'b0;
        nxt         = ctx.state;

        // A posted command replaces the held one.
        cmd = (tick.posted_command != CMD_NONE) ? tick.posted_command : ctx.pending;
        ctx_next.pending = cmd;

        case (ctx.state)
            ST_IDLE:
            begin
                ctx_next.pending = CMD_NONE;
                if (cmd == CMD_START)
                begin
                    if (!tick.binding_ready)
                    begin
                        reject = REJ_BINDING;
                    end
                    else if (!tick.setpoint_ready)
                    begin
                        reject = REJ_CONFIG;
                    end
                    else if (tick.hard_fault_latched)
                    begin
                        reject = REJ_FAULT;
                        nxt    = ST_FAULT;
                    end
                    else if (tick.setpoint_direction[1])
                    begin
                        reject = REJ_DIRECTION;
                    end
                    else
                    begin
                        ctx_next.run_permit     = 1'b1;
                        ctx_next.held_direction = tick.setpoint_direction[0];
                        nxt                     = ST_STARTUP;
                    end
                end
            end
            ST_STARTUP:
            begin
                ctx_next.pending = CMD_NONE;
                if (tick.hard_fault_latched)
                begin
                    stop_p              = 1'b1;
                    ctx_next.run_permit = 1'b0;
                    nxt                 = ST_FAULT;
                end
                else if (cmd == CMD_STOP)
                begin
                    stop_p              = 1'b1;
                    ctx_next.run_permit = 1'b0;
                    nxt                 = ST_IDLE;
                end
                else
                begin
                    settle_next = settle_dec;
                    if (settle_dec == '0)
                    begin
                        nxt = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                ctx_next.pending = CMD_NONE;
                if (tick.hard_fault_latched)
                begin
                    nxt = ST_FAULT;
                end
                else if (cmd == CMD_STOP)
                begin
                    nxt = ST_IDLE;
                end
            end
            ST_FAULT:
            begin
                ctx_next.pending = CMD_NONE;
                if (cmd == CMD_RESET)
                begin
                    clr_p = 1'b1;
                    nxt   = ST_IDLE;
                end
            end
            default:
            begin
                // Init, and any unexpected code, waits for the callbacks.
                nxt = tick.callbacks_bound ? ST_IDLE : ST_INIT;
            end
        endcase

        if (nxt != ctx.state)
        begin
            // Exit action of the state being left.
            if (ctx.state == ST_IDLE)
            begin
                ctx_next.lock_flag = 1'b1;
            end
            else if (ctx.state == ST_RUN)
            begin
                stop_p              = 1'b1;
                ctx_next.run_permit = 1'b0;
            end
            // Entry action of the new state.
            if (nxt == ST_IDLE)
            begin
                ctx_next.lock_flag = 1'b0;
            end
            else if (nxt == ST_STARTUP)
            begin
                settle_next = DELAY_BITS'(delay_cfg);
                en_p        = 1'b1;
            end
            else if (nxt == ST_FAULT)
            begin
                ctx_next.lock_flag  = 1'b1;
                pwm_p               = 1'b1;
                ctx_next.run_permit = 1'b0;
            end
        end
        ctx_next.state = nxt;
    end

    // Result fields reflect the context after the tick.
    always_comb
    begin
        result.current_state       = ctx_next.state;
        result.latched_direction   = ctx_next.held_direction;
        result.run_allowed         = ctx_next.run_permit;
        result.bridge_enable_pulse = en_p;
        result.bridge_stop_pulse   = stop_p;
        result.pwm_force_off       = pwm_p;
        result.latch_clear_pulse   = clr_p;
        result.direction_locked    = ctx_next.lock_flag;
        result.start_reject        = reject;
    end

endmodule

// ----- hdl/converter_lifecycle_sequencer.sv -----
// Top level of the converter lifecycle sequencer: input register, context
// registers and result register. Depends on cls_pkg, cls_if and cls_step.

// Every tick request passes through an input register and one level of
// next-state logic into a result register. The result of a request is
// presented on the result channel when it moves from the input register
// into the result register. The block accepts one request per cycle for as
// long as results are taken. The context registers update when a request
// moves into the result register, so each tick sees the state that the
// previous tick left behind. When the result register is full and not taken,
// the input register holds one more request and then ready drops. The
// startup delay register may be written only while no request is in flight;
// it is sampled on the tick that enters startup, and a delay of zero enters
// run on the first startup tick.

module converter_lifecycle_sequencer #(
    parameter int DELAY_BITS = cls_pkg::DELAY_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cls_tick_if.sink                      tick,
    cls_result_if.source                  result,
    input  logic                          cfg_wr_en,
    input  logic [cls_pkg::CFG_WIDTH-1:0] cfg_wr_data
);
    import cls_pkg::*;

    logic [CFG_WIDTH-1:0]  delay_cfg_reg;
    cls_tick_t             tick_reg;
    logic                  tick_valid_reg;
    cls_ctx_t              ctx_reg;
    cls_ctx_t              ctx_next;
    logic [DELAY_BITS-1:0] settle_reg;
    logic [DELAY_BITS-1:0] settle_next;
    cls_result_t           result_reg;
    cls_result_t           result_next;
    logic                  result_valid_reg;
    logic                  advance;
    cls_tick_t             tick_in;

    // A captured request moves on when the result register is free.
    assign advance    = tick_valid_reg && (!result_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;

    assign tick_in.posted_command     = cls_cmd_t'(tick.posted_command);
    assign tick_in.hard_fault_latched = tick.hard_fault_latched;
    assign tick_in.callbacks_bound    = tick.callbacks_bound;
    assign tick_in.binding_ready      = tick.binding_ready;
    assign tick_in.setpoint_ready     = tick.setpoint_ready;
    assign tick_in.setpoint_direction = tick.setpoint_direction;

    // Startup delay register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg_reg <= DELAY_CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            delay_cfg_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            tick_reg <= tick_in;
        end
    end

    // Tick evaluation.
    cls_step #(
        .DELAY_BITS (DELAY_BITS)
    ) u_step (
        .tick        (tick_reg),
        .ctx         (ctx_reg),
        .settle      (settle_reg),
        .delay_cfg   (delay_cfg_reg),
        .ctx_next    (ctx_next),
        .settle_next (settle_next),
        .result      (result_next)
    );

    // Context registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state          <= ST_INIT;
            ctx_reg.pending        <= CMD_NONE;
            ctx_reg.held_direction <= 1'b0;
            ctx_reg.run_permit     <= 1'b0;
            ctx_reg.lock_flag      <= 1'b0;
            settle_reg             <= '0;
        end
        else if (advance)
        begin
            ctx_reg    <= ctx_next;
            settle_reg <= settle_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid               = result_valid_reg;
    assign result.current_state       = result_reg.current_state;
    assign result.latched_direction   = result_reg.latched_direction;
    assign result.run_allowed         = result_reg.run_allowed;
    assign result.bridge_enable_pulse = result_reg.bridge_enable_pulse;
    assign result.bridge_stop_pulse   = result_reg.bridge_stop_pulse;
    assign result.pwm_force_off       = result_reg.pwm_force_off;
    assign result.latch_clear_pulse   = result_reg.latch_clear_pulse;
    assign result.direction_locked    = result_reg.direction_locked;
    assign result.start_reject        = result_reg.start_reject;

    // The published state always matches the context its tick produced.
    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.current_state == ctx_reg.state))
        else $error("result state differs from context state");

    // A held request is not lost while the result side stalls.
    a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid_reg && !advance) |=> tick_valid_reg)
        else $error("captured request dropped without advancing");

    // Fault entry always leaves the block in fault with the permit cleared.
    a_fault_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.pwm_force_off) |->
        (result_reg.current_state == ST_FAULT && !result_reg.run_allowed &&
         result_reg.direction_locked))
        else $error("fault entry with inconsistent outputs");

    // A bridge enable comes only with the entry into startup.
    a_enable_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.bridge_enable_pulse) |->
        (result_reg.current_state == ST_STARTUP && result_reg.run_allowed))
        else $error("bridge enable outside startup entry");

    // A start is refused only from idle, staying there or dropping to fault.
    a_reject_state: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.start_reject != REJ_NONE) |->
        (result_reg.current_state == ST_IDLE || result_reg.current_state == ST_FAULT))
        else $error("start rejection outside idle");

endmodule

// ----- test/converter_lifecycle_sequencer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for converter_lifecycle_sequencer: scheduler tick requests in, results out.
// Depends on cls_pkg, cls_if and the sequencer RTL; it predicts every result with its own state copy.

module converter_lifecycle_sequencer_test;

    import cls_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_TICKS  = 330;
    localparam int SETTLE_TAIL  = 4;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_WIDTH-1:0] cfg_wr_data;

    cls_tick_if   tick_ch ();
    cls_result_if result_ch ();

    converter_lifecycle_sequencer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // Tick requests waiting to be driven, and results predicted for accepted ticks.
    cls_tick_t   pending_ticks [$];
    cls_result_t expected_results [$];

    // Predicted sequencer context and the startup delay register copy.
    cls_state_t           seq_state;
    cls_cmd_t             held_cmd;
    logic [CFG_WIDTH-1:0] settle_count;
    logic [CFG_WIDTH-1:0] startup_delay;
    logic                 held_dir;
    logic                 permit;
    logic                 locked;

    bit tick_taken;
    bit no_gaps;
    int queued_count;
    int ticks_accepted;
    int results_checked;
    int mismatch_count;
    int stall_cycles;
    int runs_entered;
    int faults_entered;
    int rejects_seen;
    int delay_settings;

    // Advance the predicted sequencer by one tick and return the result it publishes.
    // The block uses its default counter width, which holds any register value unmasked.
    function automatic cls_result_t advance_sequencer(cls_tick_t t);
        cls_result_t r;
        cls_state_t  from_state;
        cls_state_t  to_state;
        cls_cmd_t    cmd;
        r = '0;
        if (t.posted_command != CMD_NONE)
            held_cmd = t.posted_command;
        from_state = seq_state;
        to_state = seq_state;
        cmd = held_cmd;
        case (seq_state)
            ST_IDLE:
            begin
                held_cmd = CMD_NONE;
                if (cmd == CMD_START)
                begin
                    if (!t.binding_ready)
                        r.start_reject = REJ_BINDING;
                    else if (!t.setpoint_ready)
                        r.start_reject = REJ_CONFIG;
                    else if (t.hard_fault_latched)
                    begin
                        r.start_reject = REJ_FAULT;
                        to_state = ST_FAULT;
                    end
                    else if (t.setpoint_direction[1])
                        r.start_reject = REJ_DIRECTION;
                    else
                    begin
                        permit = 1'b1;
                        held_dir = t.setpoint_direction[0];
                        to_state = ST_STARTUP;
                    end
                end
            end
            ST_STARTUP:
            begin
                held_cmd = CMD_NONE;
                if (t.hard_fault_latched)
                begin
                    r.bridge_stop_pulse = 1'b1;
                    permit = 1'b0;
                    to_state = ST_FAULT;
                end
                else if (cmd == CMD_STOP)
                begin
                    r.bridge_stop_pulse = 1'b1;
                    permit = 1'b0;
                    to_state = ST_IDLE;
                end
                else
                begin
                    if (settle_count != 0)
                        settle_count = settle_count - 1'b1;
                    if (settle_count == 0)
                        to_state = ST_RUN;
                end
            end
            ST_RUN:
            begin
                held_cmd = CMD_NONE;
                if (t.hard_fault_latched)
                    to_state = ST_FAULT;
                else if (cmd == CMD_STOP)
                    to_state = ST_IDLE;
            end
            ST_FAULT:
            begin
                held_cmd = CMD_NONE;
                if (cmd == CMD_RESET)
                begin
                    r.latch_clear_pulse = 1'b1;
                    to_state = ST_IDLE;
                end
            end
            default:
            begin
                // Init leaves any held command alone; an unknown state acts as init.
                from_state = ST_INIT;
                if (t.callbacks_bound)
                    to_state = ST_IDLE;
            end
        endcase

        // A transition runs the exit action of the old state, then the entry action of the new.
        if (to_state != from_state)
        begin
            if (from_state == ST_IDLE)
                locked = 1'b1;
            else if (from_state == ST_RUN)
            begin
                r.bridge_stop_pulse = 1'b1;
                permit = 1'b0;
            end
            case (to_state)
                ST_IDLE:
                    locked = 1'b0;
                ST_STARTUP:
                begin
                    settle_count = startup_delay;
                    r.bridge_enable_pulse = 1'b1;
                end
                ST_FAULT:
                begin
                    locked = 1'b1;
                    r.pwm_force_off = 1'b1;
                    permit = 1'b0;
                    faults_entered++;
                end
                ST_RUN:
                    runs_entered++;
                default:
                    ;
            endcase
        end
        if (r.start_reject != REJ_NONE)
            rejects_seen++;
        seq_state = to_state;
        r.current_state = seq_state;
        r.latched_direction = held_dir;
        r.run_allowed = permit;
        r.direction_locked = locked;
        return r;
    endfunction

    function automatic cls_tick_t make_tick(cls_cmd_t cmd, bit fault, bit bound, bit bind_rdy,
                                            bit setp_rdy, logic [1:0] dir);
        cls_tick_t t;
        t.posted_command = cmd;
        t.hard_fault_latched = fault;
        t.callbacks_bound = bound;
        t.binding_ready = bind_rdy;
        t.setpoint_ready = setp_rdy;
        t.setpoint_direction = dir;
        return t;
    endfunction

    // Random tick content: clean ticks keep every readiness flag up and the direction valid.
    function automatic cls_tick_t random_tick(cls_cmd_t cmd, bit clean);
        if (clean)
            return make_tick(cmd, $urandom_range(0, 49) == 0, 1'b1, 1'b1, 1'b1,
                             2'($urandom_range(0, 1)));
        return make_tick(cmd, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                         2'($urandom_range(0, 3)));
    endfunction

    task automatic queue_tick(cls_tick_t t);
        pending_ticks.push_back(t);
        queued_count++;
    endtask

    // One lifecycle: start, some quiet ticks, then a stop, a fault with recovery, or nothing.
    task automatic queue_lifecycle();
        int quiet;
        int ending;
        quiet = $urandom_range(0, 8);
        ending = $urandom_range(0, 3);
        queue_tick(random_tick(CMD_START, 1'b1));
        repeat (quiet)
            queue_tick(random_tick(CMD_NONE, 1'b1));
        if (ending == 0)
            queue_tick(random_tick(CMD_STOP, 1'b1));
        else if (ending == 1)
        begin
            queue_tick(make_tick(CMD_NONE, 1'b1, 1'b1, 1'b1, 1'b1, 2'($urandom_range(0, 3))));
            repeat ($urandom_range(0, 2))
                queue_tick(random_tick(cls_cmd_t'($urandom_range(0, 2)), 1'b0));
            queue_tick(random_tick(CMD_RESET, 1'b1));
        end
    endtask

    // Wait at falling edges until every request has been driven and every result has come
    // back. The idle condition must hold again after it is first seen, so a request that
    // the driver launches at the same edge is never missed.
    task automatic wait_drained();
        int quiet_edges;
        quiet_edges = 0;
        while (quiet_edges < 2)
        begin
            @(negedge clk);
            if (pending_ticks.size() == 0 && expected_results.size() == 0 && !tick_ch.valid)
                quiet_edges++;
            else
                quiet_edges = 0;
        end
    endtask

    // Called at a falling edge with the block drained; the write lands on the next rising edge.
    task automatic set_startup_delay(logic [CFG_WIDTH-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        startup_delay = value;
        delay_settings++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Request driver: a new tick goes out at a falling edge once the previous one was taken.
    always @(negedge clk)
    begin : drive_ticks
        cls_tick_t t;
        if (rst_n && (!tick_ch.valid || tick_taken))
        begin
            if (pending_ticks.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 24))
            begin
                t = pending_ticks.pop_front();
                tick_ch.valid <= 1'b1;
                tick_ch.posted_command <= t.posted_command;
                tick_ch.hard_fault_latched <= t.hard_fault_latched;
                tick_ch.callbacks_bound <= t.callbacks_bound;
                tick_ch.binding_ready <= t.binding_ready;
                tick_ch.setpoint_ready <= t.setpoint_ready;
                tick_ch.setpoint_direction <= t.setpoint_direction;
            end
            else
                tick_ch.valid <= 1'b0;
        end
        result_ch.ready <= rst_n && (no_gaps || $urandom_range(0, 99) >= 24);
    end

    // Monitor: predict on every accepted tick, check every accepted result, watch for stalls.
    always @(posedge clk)
    begin : watch_channels
        cls_tick_t   seen;
        cls_result_t want;
        bit          moved;
        moved = 1'b0;
        tick_taken <= tick_ch.valid && tick_ch.ready;
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            seen = make_tick(cls_cmd_t'(tick_ch.posted_command), tick_ch.hard_fault_latched,
                             tick_ch.callbacks_bound, tick_ch.binding_ready,
                             tick_ch.setpoint_ready, tick_ch.setpoint_direction);
            expected_results.push_back(advance_sequencer(seen));
            ticks_accepted++;
            moved = 1'b1;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            moved = 1'b1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result arrived with no tick outstanding, state %0d",
                         $time, result_ch.current_state);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("current_state", want.current_state, result_ch.current_state);
                check_field("latched_direction", 3'(want.latched_direction),
                            3'(result_ch.latched_direction));
                check_field("run_allowed", 3'(want.run_allowed), 3'(result_ch.run_allowed));
                check_field("bridge_enable_pulse", 3'(want.bridge_enable_pulse),
                            3'(result_ch.bridge_enable_pulse));
                check_field("bridge_stop_pulse", 3'(want.bridge_stop_pulse),
                            3'(result_ch.bridge_stop_pulse));
                check_field("pwm_force_off", 3'(want.pwm_force_off),
                            3'(result_ch.pwm_force_off));
                check_field("latch_clear_pulse", 3'(want.latch_clear_pulse),
                            3'(result_ch.latch_clear_pulse));
                check_field("direction_locked", 3'(want.direction_locked),
                            3'(result_ch.direction_locked));
                check_field("start_reject", want.start_reject, result_ch.start_reject);
                results_checked++;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : run_test
        int phase_delays [6];
        int phase_end;
        // Drive every input to a known value and reset the predicted context.
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.posted_command = CMD_NONE;
        tick_ch.hard_fault_latched = 1'b0;
        tick_ch.callbacks_bound = 1'b0;
        tick_ch.binding_ready = 1'b0;
        tick_ch.setpoint_ready = 1'b0;
        tick_ch.setpoint_direction = 2'd0;
        result_ch.ready = 1'b0;
        seq_state = ST_INIT;
        held_cmd = CMD_NONE;
        settle_count = '0;
        startup_delay = DELAY_CFG_RESET;
        held_dir = 1'b0;
        permit = 1'b0;
        locked = 1'b0;
        phase_delays = '{3, 1, 65535, 0, 2, 5};
        phase_delays[5] = $urandom_range(4, 12);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset delay: init holding a start, every reject, aborts, fault.
        queue_tick(make_tick(CMD_START, 1'b0, 1'b0, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_NONE, 1'b0, 1'b1, 1'b0, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_NONE, 1'b0, 1'b1, 1'b0, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b0, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd2));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd3));
        queue_tick(make_tick(CMD_NONE, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd1));
        queue_tick(make_tick(CMD_STOP, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_NONE, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_RESET, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b1, 1'b1, 1'b1, 1'b1, 2'd1));
        queue_tick(make_tick(CMD_RESET, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3));
        wait_drained();

        // Directed ticks with zero delay: run on the first startup tick, stop and fault from run.
        set_startup_delay('0);
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd1));
        queue_tick(make_tick(CMD_NONE, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_RESET, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_STOP, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_NONE, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_NONE, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_RESET, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        queue_tick(make_tick(CMD_STOP, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0));
        wait_drained();

        // Random phases, one per delay setting; mostly whole lifecycles, some noise.
        foreach (phase_delays[p])
        begin
            set_startup_delay(phase_delays[p][CFG_WIDTH-1:0]);
            no_gaps = (p == 1);
            phase_end = queued_count + PHASE_TICKS;
            while (queued_count < phase_end)
            begin
                if ($urandom_range(0, 99) < 75)
                    queue_lifecycle();
                else
                    repeat ($urandom_range(1, 4))
                        queue_tick(random_tick(cls_cmd_t'($urandom_range(0, 3)), 1'b0));
            end
            wait_drained();
        end
        no_gaps = 1'b0;

        // Let any stray result show up before the verdict.
        repeat (SETTLE_TAIL) @(posedge clk);
        $display("Checked %0d results for %0d ticks across %0d delay settings.",
                 results_checked, ticks_accepted, delay_settings);
        $display("Entered run %0d times and fault %0d times; %0d starts were refused.",
                 runs_entered, faults_entered, rejects_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
